@@ design/aes_pkg.sv @@
// Package for the AES-128 block cipher: types, S-box tables and round functions.
`timescale 1ns / 1ps
`default_nettype none
package aes_pkg;

	localparam int unsigned NumRounds = 10;
	localparam int unsigned KeyWidth  = 64;
	localparam int unsigned CfgIdxW   = 1;

	typedef enum logic [CfgIdxW-1:0] {
		REG_KEY_UPPER = 1'b0,
		REG_KEY_LOWER = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		OP_ENCRYPT = 1'b0,
		OP_DECRYPT = 1'b1
	} op_t;

	typedef logic [127:0] block_t;
	typedef logic [127:0] rkey_t;

	// What one round cell hands to the next.
	typedef struct packed {
		logic   valid;
		op_t    op;
		block_t state;
		rkey_t  fkey;   // forward schedule key of this round
		rkey_t  dkey;   // key for decryption, walking the schedule backward
	} cell_bus_t;

	function automatic logic [7:0] sbox(input logic [7:0] x);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
		8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
		8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
		8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
		8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
		8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
		8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
		8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
		8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
		8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
		8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
		8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
		8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
		8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
		8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
		8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16};
		return t[x];
	endfunction

	function automatic logic [7:0] inv_sbox(input logic [7:0] x);
		logic [7:0] t [256];
		t = '{
		8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
		8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
		8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
		8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
		8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
		8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
		8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
		8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
		8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
		8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
		8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
		8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
		8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
		8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
		8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D};
		return t[x];
	endfunction

	function automatic logic [7:0] xt(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1B : 8'h00);
	endfunction

	function automatic logic [7:0] rcon(input logic [3:0] rnd);
		logic [7:0] r;
		r = 8'h01;
		for (int i = 1; i < 10; i++) begin
			if (i < int'(rnd)) r = xt(r);
		end
		return r;
	endfunction

	// byte r of column c; byte 0 of the block is most significant
	function automatic logic [7:0] getb(input block_t s, input int r, input int c);
		return s[127 - 8*(4*c + r) -: 8];
	endfunction

	function automatic block_t sub_shift(input block_t s);
		block_t o;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				o[127 - 8*(4*c + r) -: 8] = sbox(getb(s, r, (c + r) & 3));
		return o;
	endfunction

	function automatic block_t inv_shift_sub(input block_t s);
		block_t o;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				o[127 - 8*(4*((c + r) & 3) + r) -: 8] = inv_sbox(getb(s, r, c));
		return o;
	endfunction

	function automatic block_t mix(input block_t s);
		block_t o;
		logic [7:0] a0, a1, a2, a3;
		for (int c = 0; c < 4; c++) begin
			a0 = getb(s, 0, c); a1 = getb(s, 1, c); a2 = getb(s, 2, c); a3 = getb(s, 3, c);
			o[127 - 8*(4*c) -: 8]     = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
			o[127 - 8*(4*c + 1) -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
			o[127 - 8*(4*c + 2) -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
			o[127 - 8*(4*c + 3) -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
		end
		return o;
	endfunction

	function automatic block_t inv_mix(input block_t s);
		block_t o;
		logic [7:0] a [4];
		logic [7:0] x2 [4];
		logic [7:0] x4 [4];
		logic [7:0] x8 [4];
		logic [7:0] m9 [4];
		logic [7:0] mb [4];
		logic [7:0] md [4];
		logic [7:0] me [4];
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				a[r]  = getb(s, r, c);
				x2[r] = xt(a[r]);
				x4[r] = xt(x2[r]);
				x8[r] = xt(x4[r]);
				m9[r] = x8[r] ^ a[r];
				mb[r] = x8[r] ^ x2[r] ^ a[r];
				md[r] = x8[r] ^ x4[r] ^ a[r];
				me[r] = x8[r] ^ x4[r] ^ x2[r];
			end
			for (int r = 0; r < 4; r++)
				o[127 - 8*(4*c + r) -: 8] = me[r] ^ mb[(r + 1) & 3] ^ md[(r + 2) & 3]
					^ m9[(r + 3) & 3];
		end
		return o;
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
	endfunction

	// next key of the forward schedule
	function automatic rkey_t key_next(input rkey_t k, input logic [3:0] rnd);
		logic [31:0] w0, w1, w2, w3, t;
		t  = sub_word({k[23:0], k[31:24]}) ^ {rcon(rnd), 24'h0};
		w0 = k[127:96] ^ t;
		w1 = k[95:64] ^ w0;
		w2 = k[63:32] ^ w1;
		w3 = k[31:0] ^ w2;
		return {w0, w1, w2, w3};
	endfunction

	// previous key of the schedule, undoing key round rnd
	function automatic rkey_t key_prev(input rkey_t k, input logic [3:0] rnd);
		logic [31:0] w0, w1, w2, w3;
		w3 = k[31:0] ^ k[63:32];
		w2 = k[63:32] ^ k[95:64];
		w1 = k[95:64] ^ k[127:96];
		w0 = k[127:96] ^ sub_word({w3[23:0], w3[31:24]}) ^ {rcon(rnd), 24'h0};
		return {w0, w1, w2, w3};
	endfunction

endpackage
`default_nettype wire

@@ design/aes_stream_if.sv @@
// Valid/ready stream interfaces: blocks in and results out.
`timescale 1ns / 1ps
`default_nettype none
interface aes_stream_if #(parameter int unsigned DataWidth = 64);
	logic                 valid;
	logic                 ready;
	logic                 op;
	logic [DataWidth-1:0] block_upper;
	logic [DataWidth-1:0] block_lower;
	modport source(output valid, op, block_upper, block_lower, input ready);
	modport sink(input valid, op, block_upper, block_lower, output ready);
endinterface

interface aes_result_if #(parameter int unsigned DataWidth = 64);
	logic                 valid;
	logic                 ready;
	logic [DataWidth-1:0] result_upper;
	logic [DataWidth-1:0] result_lower;
	modport source(output valid, result_upper, result_lower, input ready);
	modport sink(input valid, result_upper, result_lower, output ready);
endinterface
`default_nettype wire

@@ design/aes_round_cell.sv @@
// One cipher round cell: round transform plus one step of both key schedules.
`timescale 1ns / 1ps
`default_nettype none
module aes_round_cell #(
	parameter logic [3:0] Rnd = 4'd1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire aes_pkg::cell_bus_t din,
	output aes_pkg::cell_bus_t      dout
);
	aes_pkg::block_t enc_v, dec_v;
	aes_pkg::rkey_t  fkey_n, dkey_n;

	always_comb begin
		fkey_n = aes_pkg::key_next(din.fkey, Rnd);
		// decryption key walks from round 10 down: this cell needs round 10-Rnd
		dkey_n = aes_pkg::key_prev(din.dkey, 4'(11) - Rnd);
		enc_v  = aes_pkg::sub_shift(din.state);
		if (Rnd != 4'(aes_pkg::NumRounds)) enc_v = aes_pkg::mix(enc_v);
		enc_v  = enc_v ^ fkey_n;
		dec_v  = aes_pkg::inv_shift_sub(din.state) ^ dkey_n;
		if (Rnd != 4'(aes_pkg::NumRounds)) dec_v = aes_pkg::inv_mix(dec_v);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout <= '0;
		end else if (en) begin
			dout.valid <= din.valid;
			dout.op    <= din.op;
			dout.state <= (din.op == aes_pkg::OP_DECRYPT) ? dec_v : enc_v;
			dout.fkey  <= fkey_n;
			dout.dkey  <= dkey_n;
		end
	end
endmodule
`default_nettype wire

@@ design/aes_key_entry.sv @@
// Entry cell: key registers, last-round key derivation and initial AddRoundKey.
`timescale 1ns / 1ps
`default_nettype none
module aes_key_entry (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [aes_pkg::CfgIdxW-1:0]    cfg_idx,
	input  wire logic [aes_pkg::KeyWidth-1:0]   cfg_data,
	input  wire logic                           en,
	input  wire logic                           in_valid,
	input  wire logic                           in_op,
	input  wire aes_pkg::block_t                in_block,
	output logic                                busy,
	output aes_pkg::cell_bus_t                  dout
);
	logic [aes_pkg::KeyWidth-1:0] key_upper_q, key_lower_q;
	aes_pkg::rkey_t last_key_q;
	aes_pkg::rkey_t key0;
	logic [3:0]     kcnt_q;
	logic           kbusy_q;
	logic           take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_upper_q <= '0;
			key_lower_q <= '0;
		end else if (cfg_we) begin
			unique case (aes_pkg::cfg_reg_t'(cfg_idx))
				aes_pkg::REG_KEY_UPPER: key_upper_q <= cfg_data;
				aes_pkg::REG_KEY_LOWER: key_lower_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign key0 = {key_upper_q, key_lower_q};

	// Round-10 key: one schedule step per cycle after reset or a key write;
	// input is held off until it is done.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_key_q <= '0;
			kcnt_q     <= '0;
			kbusy_q    <= 1'b1;
		end else if (cfg_we) begin
			kcnt_q  <= '0;
			kbusy_q <= 1'b1;
		end else if (kbusy_q) begin
			if (kcnt_q == 4'd0) last_key_q <= key0;
			else                last_key_q <= aes_pkg::key_next(last_key_q, kcnt_q);
			if (kcnt_q == 4'(aes_pkg::NumRounds)) kbusy_q <= 1'b0;
			kcnt_q <= kcnt_q + 4'd1;
		end
	end

	assign busy = kbusy_q;
	assign take = in_valid && !kbusy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout <= '0;
		end else if (en) begin
			dout.valid <= take;
			dout.op    <= aes_pkg::op_t'(in_op);
			dout.state <= in_block ^ (in_op ? last_key_q : key0);
			dout.fkey  <= key0;
			dout.dkey  <= last_key_q;
		end
	end
endmodule
`default_nettype wire

@@ design/aes128_block_cipher.sv @@
// Top level: AES-128 ECB cipher as a chain of round cells.
//
// Usage:
//   Input channel "in" carries op (0 encrypt, 1 decrypt) and a 128-bit block
//   split in block_upper/block_lower, byte 0 most significant. Output channel
//   "res" carries the 128-bit result. A transaction happens when valid and
//   ready are both high at a rising clk edge.
//   The key is written through cfg_we/cfg_idx/cfg_data: index 0 is key_upper,
//   index 1 key_lower. Write it only while the block is idle. After reset and
//   after each key write in.ready stays low while the round-10 key is derived
//   one schedule step per cycle. A block passes one entry cell, ten round
//   cells and one output register. Throughput: one block per cycle while not
//   stalled and the key is ready, set by the unrolled round cells, each of
//   which does one round. Stall: when res.ready is low and res.valid is high
//   the whole chain holds; in.ready is high whenever the output register is
//   empty or being taken and the key is ready.
//   Reset (arst_n low) clears the key to zero and empties the chain.
`timescale 1ns / 1ps
`default_nettype none
module aes128_block_cipher (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [aes_pkg::CfgIdxW-1:0]   cfg_idx,
	input  wire logic [aes_pkg::KeyWidth-1:0]  cfg_data,
	aes_stream_if.sink                         in,
	aes_result_if.source                       res
);
	aes_pkg::cell_bus_t chain [11];
	logic en;
	logic key_busy;
	logic out_valid_q;
	aes_pkg::block_t out_q;

	assign en     = !out_valid_q || res.ready;
	assign in.ready = en && !key_busy;

	aes_key_entry u_entry (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.en(en), .in_valid(in.valid), .in_op(in.op),
		.in_block({in.block_upper, in.block_lower}),
		.busy(key_busy),
		.dout(chain[0])
	);

	for (genvar g = 1; g <= 10; g++) begin : g_round
		aes_round_cell #(.Rnd(4'(g))) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.din(chain[g-1]), .dout(chain[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (en) out_valid_q <= chain[10].valid;
	end

	always_ff @(posedge clk) begin
		if (en) out_q <= chain[10].state;
	end

	assign res.valid        = out_valid_q;
	assign res.result_upper = out_q[127:64];
	assign res.result_lower = out_q[63:0];

`ifndef SYNTHESIS
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.ready) |=> (res.valid && $stable(res.result_upper)))
		else $error("result changed while stalled");
	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(!res.valid && !key_busy) |-> in.ready)
		else $error("input stalled with empty output");
	a_chain_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(chain[10].valid))
		else $error("chain moved during stall");
`endif
endmodule
`default_nettype wire

@@ tb/sv/aes128_block_cipher_checker.sv @@
// Checker for the AES-128 ECB cipher: predicts each result and compares it with the output.
`timescale 1ns / 1ps
module aes128_block_cipher_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [aes_pkg::CfgIdxW-1:0]  cfg_idx,
	input  logic [63:0]                   cfg_data,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic                          in_op,
	input  logic [63:0]                   in_upper,
	input  logic [63:0]                   in_lower,
	input  logic                          res_valid,
	input  logic                          res_ready,
	input  logic [63:0]                   res_upper,
	input  logic [63:0]                   res_lower,
	output int                            errors,
	output int                            pending
);
	logic [127:0] key_q;
	logic [127:0] cipher_q [$];
	logic [7:0]   fwd_sbox [256];
	logic [7:0]   rev_sbox [256];

	// GF(2^8) doubling
	function automatic logic [7:0] gdbl(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		p = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (a[i]) p ^= b;
			b = gdbl(b);
		end
		return p;
	endfunction

	// state bytes st[r + 4c], byte 0 most significant
	function automatic logic [127:0] aes_cipher(input logic [127:0] key, input logic dec,
			input logic [127:0] blk);
		logic [31:0] w [44];
		logic [7:0]  st [16];
		logic [7:0]  t [16];
		logic [7:0]  rc;
		logic [31:0] x;
		logic [7:0]  m [4];
		logic [127:0] o;
		int rnd;
		rc = 8'h01;
		for (int i = 0; i < 4; i++) w[i] = key[127 - 32*i -: 32];
		for (int i = 4; i < 44; i++) begin
			x = w[i-1];
			if (i % 4 == 0) begin
				x = {x[23:0], x[31:24]};
				x = {fwd_sbox[x[31:24]], fwd_sbox[x[23:16]], fwd_sbox[x[15:8]],
					fwd_sbox[x[7:0]]} ^ {rc, 24'h0};
				rc = gdbl(rc);
			end
			w[i] = w[i-4] ^ x;
		end
		for (int i = 0; i < 16; i++) st[i] = blk[127 - 8*i -: 8];
		if (dec) m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
		else m = '{8'h02, 8'h03, 8'h01, 8'h01};
		for (int s = 0; s <= 10; s++) begin
			rnd = dec ? 10 - s : s;
			if (s > 0) begin
				t = st;
				for (int c = 0; c < 4; c++)
					for (int r = 0; r < 4; r++)
						if (dec) st[r + 4*((c + r) & 3)] = rev_sbox[t[r + 4*c]];
						else st[r + 4*c] = fwd_sbox[t[r + 4*((c + r) & 3)]];
				if (!dec && s != 10) begin
					t = st;
					for (int c = 0; c < 4; c++)
						for (int r = 0; r < 4; r++)
							st[r + 4*c] = gmul(m[(4 - r) & 3], t[4*c]) ^
								gmul(m[(5 - r) & 3], t[4*c + 1]) ^
								gmul(m[(6 - r) & 3], t[4*c + 2]) ^
								gmul(m[(7 - r) & 3], t[4*c + 3]);
				end
			end
			for (int c = 0; c < 4; c++)
				for (int r = 0; r < 4; r++)
					st[r + 4*c] ^= w[rnd*4 + c][31 - 8*r -: 8];
			if (dec && s > 0 && s != 10) begin
				t = st;
				for (int c = 0; c < 4; c++)
					for (int r = 0; r < 4; r++)
						st[r + 4*c] = gmul(m[(4 - r) & 3], t[4*c]) ^
							gmul(m[(5 - r) & 3], t[4*c + 1]) ^
							gmul(m[(6 - r) & 3], t[4*c + 2]) ^
							gmul(m[(7 - r) & 3], t[4*c + 3]);
			end
		end
		for (int i = 0; i < 16; i++) o[127 - 8*i -: 8] = st[i];
		return o;
	endfunction

	// S-box built from its algebraic definition: inverse in GF(2^8), then affine map
	initial begin
		logic [7:0] inv, b;
		for (int i = 0; i < 256; i++) begin
			inv = 8'h00;
			for (int j = 1; j < 256; j++)
				if (gmul(i[7:0], j[7:0]) == 8'h01) inv = j[7:0];
			b = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
				^ {inv[3:0], inv[7:4]} ^ 8'h63;
			fwd_sbox[i] = b;
			rev_sbox[b] = i[7:0];
		end
	end

	assign pending = cipher_q.size();

	initial errors = 0;

	always @(posedge clk or negedge arst_n) begin
		logic [127:0] want;
		if (!arst_n) begin
			key_q <= '0;
			cipher_q.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_idx == aes_pkg::REG_KEY_UPPER) key_q[127:64] <= cfg_data;
				else key_q[63:0] <= cfg_data;
			end
			if (in_valid && in_ready)
				cipher_q.push_back(aes_cipher(key_q, in_op, {in_upper, in_lower}));
			if (res_valid && res_ready) begin
				if (cipher_q.size() == 0) begin
					$display("%t: unexpected result %h_%h", $time, res_upper, res_lower);
					errors++;
				end else begin
					want = cipher_q.pop_front();
					if (res_upper !== want[127:64]) begin
						$display("%t: result_upper expected %h actual %h", $time,
							want[127:64], res_upper);
						errors++;
					end
					if (res_lower !== want[63:0]) begin
						$display("%t: result_lower expected %h actual %h", $time,
							want[63:0], res_lower);
						errors++;
					end
				end
			end
		end
	end
endmodule

@@ tb/sv/aes128_block_cipher_tb.sv @@
// Testbench top for the AES-128 ECB cipher: reset, key writes, block stimulus, verdict.
`timescale 1ns / 1ps
module aes128_block_cipher_tb;
	logic clk;
	logic arst_n;
	logic cfg_we;
	aes_pkg::cfg_reg_t cfg_idx;
	logic [63:0] cfg_data;
	int errors;
	int pending;
	int cycles;
	bit hold_off;

	aes_stream_if #(.DataWidth(64)) in_ch ();
	aes_result_if #(.DataWidth(64)) res_ch ();

	aes128_block_cipher u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.in       (in_ch.sink),
		.res      (res_ch.source)
	);

	aes128_block_cipher_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.in_op     (in_ch.op),
		.in_upper  (in_ch.block_upper),
		.in_lower  (in_ch.block_lower),
		.res_valid (res_ch.valid),
		.res_ready (res_ch.ready),
		.res_upper (res_ch.result_upper),
		.res_lower (res_ch.result_lower),
		.errors    (errors),
		.pending   (pending)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("aes128_block_cipher_tb failed");
			$finish;
		end
	end

	// receiver stall pattern, plus one long hold-off on request
	initial begin
		int mode;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off) begin
				res_ch.ready <= 1'b0;
				for (int i = 0; i < 60; i++) @(negedge clk);
				hold_off = 1'b0;
			end
			mode = (cycles / 300) % 3;
			if (mode == 0) res_ch.ready <= 1'b1;
			else if (mode == 1) res_ch.ready <= ($urandom_range(0, 3) != 0);
			else res_ch.ready <= ($urandom_range(0, 1) != 0);
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [63:0] pick_word();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return 64'h1 << $urandom_range(0, 63);
			default: return rand64();
		endcase
	endfunction

	// send one block and hold it until the cipher takes it
	task automatic send_block(input aes_pkg::op_t op, input logic [63:0] u,
			input logic [63:0] l);
		in_ch.valid <= 1'b1;
		in_ch.op <= op;
		in_ch.block_upper <= u;
		in_ch.block_lower <= l;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_random(input int count);
		int burst;
		int gap;
		burst = 0;
		for (int n = 0; n < count; n++) begin
			if (burst == 0) begin
				gap = $urandom_range(0, 6);
				if (gap != 0) begin
					in_ch.valid <= 1'b0;
					repeat (gap) @(negedge clk);
				end
				burst = $urandom_range(1, 30);
			end
			burst--;
			send_block(aes_pkg::op_t'($urandom_range(0, 1)), pick_word(), pick_word());
		end
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (16) @(negedge clk);
	endtask

	task automatic write_key(input logic [63:0] ku, input logic [63:0] kl);
		cfg_we <= 1'b1;
		cfg_idx <= aes_pkg::REG_KEY_UPPER;
		cfg_data <= ku;
		@(negedge clk);
		cfg_idx <= aes_pkg::REG_KEY_LOWER;
		cfg_data <= kl;
		@(negedge clk);
		cfg_we <= 1'b0;
		repeat (3) @(negedge clk);
	endtask

	initial begin
		cycles = 0;
		hold_off = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = aes_pkg::REG_KEY_UPPER;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.op = aes_pkg::OP_ENCRYPT;
		in_ch.block_upper = '0;
		in_ch.block_lower = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// all-zero key left from reset
		send_block(aes_pkg::OP_ENCRYPT, '0, '0);
		send_block(aes_pkg::OP_DECRYPT, '0, '0);
		send_block(aes_pkg::OP_ENCRYPT, '1, '1);
		send_block(aes_pkg::OP_DECRYPT, '1, '1);
		drain();
		// standard test vector key
		write_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
		send_block(aes_pkg::OP_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
		send_block(aes_pkg::OP_DECRYPT, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
		send_block(aes_pkg::OP_ENCRYPT, 64'h8000000000000000, 64'h0000000000000001);
		send_block(aes_pkg::OP_DECRYPT, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
		drain();
		write_key('1, '1);
		send_block(aes_pkg::OP_ENCRYPT, '0, '1);
		send_block(aes_pkg::OP_DECRYPT, '1, '0);
		drain();

		// back-pressure: long hold-off while the sender keeps offering
		hold_off = 1'b1;
		send_random(40);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			write_key(ph == 0 ? 64'h0 : pick_word(), ph == 0 ? 64'h0 : pick_word());
			send_random(195);
			drain();
		end

		if (errors == 0) begin
			$display("aes128_block_cipher_tb passed");
		end else begin
			$display("aes128_block_cipher_tb failed");
		end
		$finish;
	end
endmodule

@@ aes128_block_cipher.f @@
design/aes_pkg.sv
design/aes_stream_if.sv
design/aes_round_cell.sv
design/aes_key_entry.sv
design/aes128_block_cipher.sv
tb/sv/aes128_block_cipher_checker.sv
tb/sv/aes128_block_cipher_tb.sv
